/* rtl/ops_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ops_pkg
// Shared types and Q2.14 constants of the open palm scoring pipeline.
// ----------------------------------------------------------------------------
package ops_pkg;

   localparam int PIPE_STAGES   = 12;
   localparam int SMOOTH_STAGES = 5;

   localparam logic [14:0] ONE_Q14 = 15'd16384;

   // smoothstep edges, Q2.14
   localparam logic [15:0] GAP_LO   = 16'd3604;
   localparam logic [15:0] GAP_HI   = 16'd8520;
   localparam logic [15:0] FING_LO  = 16'd10158;
   localparam logic [15:0] FING_HI  = 16'd14746;
   localparam logic [15:0] THUMB_LO = 16'd5734;
   localparam logic [15:0] THUMB_HI = 16'd12288;

   localparam logic [12:0] GAP_SPAN   = 13'(GAP_HI - GAP_LO);
   localparam logic [12:0] FING_SPAN  = 13'(FING_HI - FING_LO);
   localparam logic [12:0] THUMB_SPAN = 13'(THUMB_HI - THUMB_LO);

   // floor(2^32 / span), quotient estimate is at most one low
   localparam logic [19:0] GAP_RECIP   = 20'((64'd1 << 32) / GAP_SPAN);
   localparam logic [19:0] FING_RECIP  = 20'((64'd1 << 32) / FING_SPAN);
   localparam logic [19:0] THUMB_RECIP = 20'((64'd1 << 32) / THUMB_SPAN);

   // 3 * 1.0 in Q2.14, used by the cubic and by the confidence weight
   localparam logic [15:0] THREE_Q14 = 16'd49152;

   // csr register indexes
   localparam logic [1:0] REG_TRACKING_MIN      = 2'd0;
   localparam logic [1:0] REG_FINGER_DETECT_MIN = 2'd1;
   localparam logic [1:0] REG_THUMB_DETECT_MIN  = 2'd2;

   localparam logic [15:0] TRACKING_MIN_RST      = 16'd11469;
   localparam logic [15:0] FINGER_DETECT_MIN_RST = 16'd11796;
   localparam logic [15:0] THUMB_DETECT_MIN_RST  = 16'd7373;

   typedef enum logic [1:0] {
      SMOOTH_GAP,
      SMOOTH_FINGER,
      SMOOTH_THUMB
   } smooth_kind_type;

   // per-frame data that rides beside the smoothstep units
   typedef struct packed {
      logic        ok;
      logic [15:0] fmin;
      logic [15:0] thumb;
      logic [14:0] fs;
      logic        det;
   } side_type;

   function automatic logic [15:0] edge_lo(input smooth_kind_type kind);
      logic [15:0] r;
      unique case (kind)
         SMOOTH_GAP:    r = GAP_LO;
         SMOOTH_FINGER: r = FING_LO;
         SMOOTH_THUMB:  r = THUMB_LO;
         default:       r = GAP_LO;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] edge_hi(input smooth_kind_type kind);
      logic [15:0] r;
      unique case (kind)
         SMOOTH_GAP:    r = GAP_HI;
         SMOOTH_FINGER: r = FING_HI;
         SMOOTH_THUMB:  r = THUMB_HI;
         default:       r = GAP_HI;
      endcase
      return r;
   endfunction

   function automatic logic [12:0] edge_span(input smooth_kind_type kind);
      logic [12:0] r;
      unique case (kind)
         SMOOTH_GAP:    r = GAP_SPAN;
         SMOOTH_FINGER: r = FING_SPAN;
         SMOOTH_THUMB:  r = THUMB_SPAN;
         default:       r = GAP_SPAN;
      endcase
      return r;
   endfunction

   function automatic logic [19:0] edge_recip(input smooth_kind_type kind);
      logic [19:0] r;
      unique case (kind)
         SMOOTH_GAP:    r = GAP_RECIP;
         SMOOTH_FINGER: r = FING_RECIP;
         SMOOTH_THUMB:  r = THUMB_RECIP;
         default:       r = GAP_RECIP;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/open_palm_score.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// open_palm_score
// Open palm scoring of one hand-measurement frame per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one frame per transfer, rsp_* one score per frame, in order.
//   csr_* writes the three Q2.14 thresholds; write only while the pipeline
//   is empty.
// Pipeline: twelve register stages: one input stage, five per smoothstep
//   unit (two multiplies for the divide, two for the cubic) with the thumb
//   unit after the gap unit, and one stage that forms confidence. Throughput:
//   one frame per cycle while the output is not stalled.
// Stall: when rsp_tready is low the output holds; empty stages in front of
//   it still fill, so req_tready stays high until every stage holds a frame.
// Reset: clears all valid bits and loads the threshold reset values.
// An invalid frame returns zeros in every result field.
// ----------------------------------------------------------------------------
module open_palm_score (
   input  wire logic         clock,
   input  wire logic         reset,
   // tdata: tracking_quality[14:0], thumb, index, middle, ring, little,
   //        thumb_index_gap (16 each), zero pad bit 111
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [111:0] req_tdata,
   // tuser: hand_present, quality_valid
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: finger_extension_min[15:0], thumb_openness[31:16],
   //        confidence[46:32], zero pad bit 47
   output logic [47:0]       rsp_tdata,
   // tuser: input_valid, detected
   output logic [1:0]        rsp_tuser,
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_wr_index,
   input  wire logic [15:0]  csr_wr_data
);
   import ops_pkg::*;

   logic [15:0] tracking_min_ff;
   logic [15:0] finger_detect_min_ff;
   logic [15:0] thumb_detect_min_ff;

   logic [PIPE_STAGES-1:0] stage_en;

   side_type    side_ff [1:PIPE_STAGES-1];
   side_type    side_in [1:PIPE_STAGES-1];
   logic [15:0] gap1_ff;

   logic [14:0] tracking_quality;
   logic [15:0] ext_thumb, ext_index, ext_middle, ext_ring, ext_little, gap;
   logic [15:0] min_a, min_b;
   logic [14:0] gap_res, fing_res, thumb_res;
   logic [15:0] open_pt;

   logic        out_ok_ff, out_det_ff;
   logic [15:0] out_fmin_ff, out_open_ff;
   logic [14:0] out_conf_ff;
   logic [31:0] conf_prod;
   logic [14:0] conf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_min_ff      <= TRACKING_MIN_RST;
         finger_detect_min_ff <= FINGER_DETECT_MIN_RST;
         thumb_detect_min_ff  <= THUMB_DETECT_MIN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_wr_index)
            REG_TRACKING_MIN:      tracking_min_ff      <= csr_wr_data;
            REG_FINGER_DETECT_MIN: finger_detect_min_ff <= csr_wr_data;
            REG_THUMB_DETECT_MIN:  thumb_detect_min_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   ops_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .stage_en  (stage_en)
   );

   assign tracking_quality = req_tdata[14:0];
   assign ext_thumb        = req_tdata[30:15];
   assign ext_index        = req_tdata[46:31];
   assign ext_middle       = req_tdata[62:47];
   assign ext_ring         = req_tdata[78:63];
   assign ext_little       = req_tdata[94:79];
   assign gap              = req_tdata[110:95];

   assign min_a = (ext_middle < ext_index) ? ext_middle : ext_index;
   assign min_b = (ext_little < ext_ring) ? ext_little : ext_ring;

   // thumb openness joins the side data once the gap score is out
   assign open_pt = (side_ff[6].thumb > {1'b0, gap_res}) ? side_ff[6].thumb
                                                          : {1'b0, gap_res};

   always_comb begin
      side_in[1].ok    = req_tuser[0] & req_tuser[1] &
                         ({1'b0, tracking_quality} >= tracking_min_ff);
      side_in[1].fmin  = (min_b < min_a) ? min_b : min_a;
      side_in[1].thumb = ext_thumb;
      side_in[1].fs    = '0;
      side_in[1].det   = 1'b0;
      for (int k = 2; k < PIPE_STAGES; k++) begin
         side_in[k] = side_ff[k-1];
      end
      side_in[7].thumb = open_pt;
      side_in[7].fs    = fing_res;
      side_in[7].det   = (side_ff[6].fmin >= finger_detect_min_ff) &&
                         (open_pt >= thumb_detect_min_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         gap1_ff <= gap;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
         if (stage_en[k-1]) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   ops_smooth u_gap_smooth (
      .clock    (clock),
      .kind     (SMOOTH_GAP),
      .stage_en (stage_en[SMOOTH_STAGES:1]),
      .value    (gap1_ff),
      .result   (gap_res)
   );

   ops_smooth u_finger_smooth (
      .clock    (clock),
      .kind     (SMOOTH_FINGER),
      .stage_en (stage_en[SMOOTH_STAGES:1]),
      .value    (side_ff[1].fmin),
      .result   (fing_res)
   );

   ops_smooth u_thumb_smooth (
      .clock    (clock),
      .kind     (SMOOTH_THUMB),
      .stage_en (stage_en[2*SMOOTH_STAGES:SMOOTH_STAGES+1]),
      .value    (open_pt),
      .result   (thumb_res)
   );

   // fs * (0.75 + 0.25 * ts) reduces to fs * (3.0 + ts) >> 16 in Q2.14
   always_comb begin
      conf_prod = 32'(side_ff[11].fs) * 32'(17'(THREE_Q14) + 17'(thumb_res));
      if (conf_prod[31:16] > 16'(ONE_Q14)) begin
         conf_in = ONE_Q14;
      end else begin
         conf_in = conf_prod[30:16];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[PIPE_STAGES-1]) begin
         out_ok_ff <= side_ff[11].ok;
         if (side_ff[11].ok) begin
            out_fmin_ff <= side_ff[11].fmin;
            out_open_ff <= side_ff[11].thumb;
            out_conf_ff <= conf_in;
            out_det_ff  <= side_ff[11].det;
         end else begin
            out_fmin_ff <= '0;
            out_open_ff <= '0;
            out_conf_ff <= '0;
            out_det_ff  <= 1'b0;
         end
      end
   end

   assign rsp_tdata = {1'b0, out_conf_ff, out_open_ff, out_fmin_ff};
   assign rsp_tuser = {out_det_ff, out_ok_ff};

endmodule
`default_nettype wire

/* rtl/ops_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ops_ctrl
// Valid bits and per-stage load enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module ops_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output logic [ops_pkg::PIPE_STAGES-1:0]       stage_en
);
   import ops_pkg::*;

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] move;

   always_comb begin
      move[PIPE_STAGES-1] = ~valid_ff[PIPE_STAGES-1] | out_ready;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         move[k] = ~valid_ff[k] | move[k+1];
      end
   end

   always_comb begin
      valid_in[0] = in_valid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_STAGES; k++) begin
            if (move[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign stage_en  = move;
   assign in_ready  = move[0];
   assign out_valid = valid_ff[PIPE_STAGES-1];

endmodule
`default_nettype wire

/* rtl/ops_smooth.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ops_smooth
// Five-stage Q2.14 smoothstep: reciprocal divide, correction, cubic.
// ----------------------------------------------------------------------------
module ops_smooth (
   input  wire logic                               clock,
   input  wire ops_pkg::smooth_kind_type           kind,
   input  wire logic [ops_pkg::SMOOTH_STAGES-1:0]  stage_en,
   input  wire logic [15:0]                        value,
   output logic [14:0]                             result
);
   import ops_pkg::*;

   logic [26:0] num1_ff, num2_ff;
   logic        lo1_ff, lo2_ff, lo3_ff, lo4_ff;
   logic        hi1_ff, hi2_ff, hi3_ff, hi4_ff;
   logic [13:0] q2_ff;
   logic [13:0] t3_ff, t4_ff;
   logic [27:0] tt4_ff;
   logic [14:0] res5_ff;

   logic [15:0] diff;
   logic [26:0] num1_in;
   logic [46:0] prod2;
   logic [13:0] q2_in;
   logic [26:0] back3;
   logic [27:0] rem3;
   logic [13:0] t3_in;
   logic [15:0] mul4;
   logic [43:0] poly5;
   logic [14:0] res5_in;

   assign diff    = value - edge_lo(kind);
   assign num1_in = {diff[12:0], 14'd0};

   assign prod2 = 47'(num1_ff) * 47'(edge_recip(kind));
   assign q2_in = prod2[45:32];

   // estimate is exact or one low
   assign back3 = 27'(q2_ff) * 27'(edge_span(kind));
   assign rem3  = {1'b0, num2_ff} - {1'b0, back3};
   assign t3_in = (rem3 >= 28'(edge_span(kind))) ? q2_ff + 14'd1 : q2_ff;

   assign mul4 = THREE_Q14 - {1'b0, t4_ff, 1'b0};

   always_comb begin
      poly5 = 44'(tt4_ff) * 44'(mul4);
      if (lo4_ff) begin
         res5_in = '0;
      end else if (hi4_ff) begin
         res5_in = ONE_Q14;
      end else begin
         res5_in = poly5[42:28];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         num1_ff <= num1_in;
         lo1_ff  <= (value <= edge_lo(kind));
         hi1_ff  <= (value >= edge_hi(kind));
      end
      if (stage_en[1]) begin
         num2_ff <= num1_ff;
         q2_ff   <= q2_in;
         lo2_ff  <= lo1_ff;
         hi2_ff  <= hi1_ff;
      end
      if (stage_en[2]) begin
         t3_ff  <= t3_in;
         lo3_ff <= lo2_ff;
         hi3_ff <= hi2_ff;
      end
      if (stage_en[3]) begin
         tt4_ff <= 28'(t3_ff) * 28'(t3_ff);
         t4_ff  <= t3_ff;
         lo4_ff <= lo3_ff;
         hi4_ff <= hi3_ff;
      end
      if (stage_en[4]) begin
         res5_ff <= res5_in;
      end
   end

   assign result = res5_ff;

endmodule
`default_nettype wire

/* verif/open_palm_score_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_palm_score_tb
// Self-checking bench for the open palm scorer. Frames go in on the req
// stream and scores come back on the rsp stream. Each accepted frame is
// scored by a Q2.14 model in the bench, and each returned score is matched
// field by field against the oldest one still due. A directed set covers
// the validity gates, smoothstep edges and detection thresholds. Random
// frames then run under several threshold settings, with random idling
// on both sides and a long output stall.
// ----------------------------------------------------------------------------
module open_palm_score_tb;
   import ops_pkg::*;

   localparam int          CLK_HALF       = 10;
   localparam int          RESET_CYCLES   = 8;
   localparam int          CYCLE_LIMIT    = 400000;
   localparam int          HOLD_CYCLES    = 60;
   localparam int          DIRECTED_COUNT = 20;
   localparam longint unsigned CONF_BASE_Q14  = 12288;  // 0.75
   localparam longint unsigned CONF_SLOPE_Q14 = 4096;   // 0.25

   typedef struct {
      bit        hand_present;
      bit        quality_valid;
      bit [14:0] tracking_quality;
      bit [15:0] thumb_extension;
      bit [15:0] finger [4];   // index, middle, ring, little
      bit [15:0] thumb_index_gap;
   } palm_frame_type;

   typedef struct {
      logic        input_valid;
      logic [15:0] finger_extension_min;
      logic [15:0] thumb_openness;
      logic [14:0] confidence;
      logic        detected;
   } palm_score_type;

   class palm_score_board;
      bit [15:0]      tracking_min;
      bit [15:0]      finger_detect_min;
      bit [15:0]      thumb_detect_min;
      palm_score_type scores_due [$];
      int unsigned    frames_seen;
      int unsigned    valid_seen;
      int unsigned    detect_seen;
      int unsigned    scores_checked;
      int unsigned    mismatches;

      function new();
         tracking_min      = TRACKING_MIN_RST;
         finger_detect_min = FINGER_DETECT_MIN_RST;
         thumb_detect_min  = THUMB_DETECT_MIN_RST;
      endfunction

      function longint unsigned smooth(longint unsigned lo, longint unsigned hi,
                                       longint unsigned v);
         longint unsigned t;
         if (v <= lo) return 0;
         if (v >= hi) return longint'(ONE_Q14);
         t = ((v - lo) << 14) / (hi - lo);
         return (t * t * (3 * 16384 - 2 * t)) >> 28;
      endfunction

      function int pending();
         return scores_due.size();
      endfunction

      function void note_frame(palm_frame_type f);
         palm_score_type  s;
         longint unsigned fmin, gap_s, open, fs, ts, conf;
         int              i;
         s = '{default: '0};
         frames_seen++;
         if (f.hand_present && f.quality_valid && f.tracking_quality >= tracking_min) begin
            fmin = f.finger[0];
            for (i = 1; i < 4; i++)
               if (f.finger[i] < fmin) fmin = f.finger[i];
            gap_s = smooth(GAP_LO, GAP_HI, f.thumb_index_gap);
            open  = (f.thumb_extension > gap_s) ? f.thumb_extension : gap_s;
            fs    = smooth(FING_LO, FING_HI, fmin);
            ts    = smooth(THUMB_LO, THUMB_HI, open);
            conf  = (fs * (CONF_BASE_Q14 * 16384 + CONF_SLOPE_Q14 * ts)) >> 28;
            if (conf > 16384) conf = 16384;
            s.input_valid          = 1'b1;
            s.finger_extension_min = 16'(fmin);
            s.thumb_openness       = 16'(open);
            s.confidence           = 15'(conf);
            s.detected             = (fmin >= finger_detect_min) && (open >= thumb_detect_min);
            valid_seen++;
            if (s.detected) detect_seen++;
         end
         scores_due.push_back(s);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_score(palm_score_type got);
         palm_score_type want;
         if (scores_due.size() == 0) begin
            $error("score transfer with no frame outstanding");
            mismatches++;
            return;
         end
         want = scores_due.pop_front();
         scores_checked++;
         compare_field("input_valid", 16'(want.input_valid), 16'(got.input_valid));
         compare_field("finger_extension_min", want.finger_extension_min,
                       got.finger_extension_min);
         compare_field("thumb_openness", want.thumb_openness, got.thumb_openness);
         compare_field("confidence", 16'(want.confidence), 16'(got.confidence));
         compare_field("detected", 16'(want.detected), 16'(got.detected));
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // tdata: tracking_quality[14:0], thumb, index, middle, ring, little,
   //        thumb_index_gap (16 each), zero pad bit 111
   logic [111:0] req_tdata = '0;
   // tuser: hand_present, quality_valid
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // tdata: finger_extension_min, thumb_openness, confidence, zero pad
   logic [47:0]  rsp_tdata;
   // tuser: input_valid, detected
   logic [1:0]   rsp_tuser;
   logic         csr_wr_en = 1'b0;
   logic [1:0]   csr_wr_index = '0;
   logic [15:0]  csr_wr_data = '0;

   palm_score_board board = new();

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int unsigned stall_orders = 0;
   int unsigned stall_taken = 0;
   int unsigned hold_left = 0;
   int unsigned input_stalls = 0;
   int unsigned settings_run = 1;
   int unsigned cycle_count = 0;

   open_palm_score uut (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_index (csr_wr_index),
      .csr_wr_data  (csr_wr_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // score receiver: checks transfers and paces rsp_tready
   always @(posedge clock) begin
      palm_score_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.finger_extension_min = rsp_tdata[15:0];
            got.thumb_openness       = rsp_tdata[31:16];
            got.confidence           = rsp_tdata[46:32];
            got.input_valid          = rsp_tuser[0];
            got.detected             = rsp_tuser[1];
            board.check_score(got);
         end
         if (req_tvalid && !req_tready) input_stalls++;
         if (stall_orders != stall_taken) begin
            stall_taken = stall_orders;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_frame(input palm_frame_type f);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, f.thumb_index_gap, f.finger[3], f.finger[2], f.finger[1],
                     f.finger[0], f.thumb_extension, f.tracking_quality};
      req_tuser  <= {f.quality_valid, f.hand_present};
      do @(posedge clock); while (!req_tready);
      board.note_frame(f);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
   endtask

   task automatic wait_for_scores();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // all three thresholds, back to back, pipeline empty
   task automatic load_thresholds(input bit [15:0] track_min, input bit [15:0] fing_min,
                                  input bit [15:0] thumb_min);
      csr_wr_en    <= 1'b1;
      csr_wr_index <= REG_TRACKING_MIN;
      csr_wr_data  <= track_min;
      @(posedge clock);
      board.tracking_min = track_min;
      csr_wr_index <= REG_FINGER_DETECT_MIN;
      csr_wr_data  <= fing_min;
      @(posedge clock);
      board.finger_detect_min = fing_min;
      csr_wr_index <= REG_THUMB_DETECT_MIN;
      csr_wr_data  <= thumb_min;
      @(posedge clock);
      board.thumb_detect_min = thumb_min;
      csr_wr_en <= 1'b0;
      settings_run++;
   endtask

   function automatic palm_frame_type directed_frame(int k);
      palm_frame_type f;
      int             i;
      f.hand_present     = 1'b1;
      f.quality_valid    = 1'b1;
      f.tracking_quality = 15'(TRACKING_MIN_RST);
      f.thumb_extension  = 16'd12000;
      for (i = 0; i < 4; i++) f.finger[i] = 16'd14000;
      f.thumb_index_gap  = 16'd5000;
      case (k)
         0: f.hand_present = 1'b0;
         1: f.quality_valid = 1'b0;
         2: f.tracking_quality = 15'(TRACKING_MIN_RST - 1);
         3: ;  // exactly at the tracking minimum
         4: begin
            f.tracking_quality = 15'h7fff;
            f.thumb_extension  = 16'hffff;
            for (i = 0; i < 4; i++) f.finger[i] = 16'hffff;
            f.thumb_index_gap  = 16'hffff;
         end
         5: begin
            f.tracking_quality = 15'(ONE_Q14);
            f.thumb_extension  = '0;
            for (i = 0; i < 4; i++) f.finger[i] = '0;
            f.thumb_index_gap  = '0;
         end
         6: begin
            f.thumb_extension = THUMB_LO;
            for (i = 0; i < 4; i++) f.finger[i] = FING_LO;
            f.thumb_index_gap = GAP_LO;
         end
         7: begin
            f.thumb_extension = THUMB_HI;
            for (i = 0; i < 4; i++) f.finger[i] = FING_HI;
            f.thumb_index_gap = GAP_HI;
         end
         8: begin
            f.thumb_extension = THUMB_LO + 16'd1;
            for (i = 0; i < 4; i++) f.finger[i] = FING_LO + 16'd1;
            f.thumb_index_gap = GAP_LO + 16'd1;
         end
         9: begin
            f.thumb_extension = '0;
            for (i = 0; i < 4; i++) f.finger[i] = FING_HI - 16'd1;
            f.thumb_index_gap = GAP_HI - 16'd1;
         end
         10, 11, 12, 13: f.finger[k - 10] = 16'd10500;  // minimum in each finger
         14: begin
            f.thumb_extension = 16'd9000;
            f.thumb_index_gap = 16'd4000;
         end
         15: begin
            f.thumb_extension = 16'd1000;
            f.thumb_index_gap = 16'd8000;
         end
         16, 17, 18: begin
            // detection thresholds hit exactly, then one below each
            for (i = 0; i < 4; i++) f.finger[i] = FINGER_DETECT_MIN_RST;
            f.thumb_extension = THUMB_DETECT_MIN_RST;
            f.thumb_index_gap = '0;
            if (k == 17) f.finger[2] = FINGER_DETECT_MIN_RST - 16'd1;
            if (k == 18) f.thumb_extension = THUMB_DETECT_MIN_RST - 16'd1;
         end
         default: begin
            // invalid frame carrying busy data
            f.hand_present     = 1'b0;
            f.quality_valid    = 1'b0;
            f.tracking_quality = 15'h7fff;
            f.thumb_extension  = 16'hffff;
            for (i = 0; i < 4; i++) f.finger[i] = 16'hffff;
            f.thumb_index_gap  = 16'hffff;
         end
      endcase
      return f;
   endfunction

   // value around a band, its edges, a threshold, or anywhere
   function automatic bit [15:0] pick_q14(input int lo, input int hi, input int thr);
      int span;
      span = (hi - lo) / 4;
      case ($urandom_range(0, 9))
         0, 1: return 16'($urandom);
         2: return 16'(lo - 1 + $urandom_range(0, 2));
         3: return 16'(hi - 1 + $urandom_range(0, 2));
         4: return 16'(thr - 1 + $urandom_range(0, 2));
         default: return 16'($urandom_range(lo - span, hi + span));
      endcase
   endfunction

   function automatic palm_frame_type random_frame();
      palm_frame_type f;
      int             i;
      if ($urandom_range(0, 9) == 0) begin
         f.hand_present  = 1'($urandom_range(0, 1));
         f.quality_valid = 1'($urandom_range(0, 1));
      end else begin
         f.hand_present  = 1'b1;
         f.quality_valid = 1'b1;
      end
      case ($urandom_range(0, 5))
         0: f.tracking_quality = 15'($urandom);
         1: f.tracking_quality = 15'(ONE_Q14);
         2: f.tracking_quality = 15'(int'(board.tracking_min) - 1 + $urandom_range(0, 2));
         default: f.tracking_quality = 15'($urandom_range(int'(board.tracking_min),
                                                          int'(ONE_Q14)));
      endcase
      f.thumb_extension = pick_q14(THUMB_LO, THUMB_HI, board.thumb_detect_min);
      for (i = 0; i < 4; i++)
         f.finger[i] = pick_q14(FING_LO, FING_HI, board.finger_detect_min);
      f.thumb_index_gap = pick_q14(GAP_LO, GAP_HI, board.thumb_detect_min);
      return f;
   endfunction

   task automatic run_random(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if (n == count / 2) wait_for_scores();
         send_frame(random_frame());
      end
      wait_for_scores();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames against the reset thresholds
      for (int k = 0; k < DIRECTED_COUNT; k++) send_frame(directed_frame(k));
      wait_for_scores();

      send_idle_pct = 25;
      recv_idle_pct = 67;
      run_random(150);
      load_thresholds('0, '0, '0);
      run_random(150);

      send_idle_pct = 67;
      recv_idle_pct = 25;
      load_thresholds(16'($urandom_range(0, 16384)), 16'($urandom_range(10000, 15000)),
                      16'($urandom_range(5000, 13000)));
      run_random(150);
      load_thresholds(16'(ONE_Q14), 16'hffff, 16'hffff);
      run_random(150);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_thresholds(16'hffff, '0, '0);
      run_random(40);
      load_thresholds(TRACKING_MIN_RST, FINGER_DETECT_MIN_RST, THUMB_DETECT_MIN_RST);

      // long output stall while frames keep coming
      stall_orders <= stall_orders + 1;
      run_random(60);
      run_random(200);

      repeat (2 * PIPE_STAGES) @(posedge clock);
      $display("frames %0d (valid %0d, detected %0d), scores checked %0d, settings %0d",
               board.frames_seen, board.valid_seen, board.detect_seen,
               board.scores_checked, settings_run);
      $display("cycles with req held off by a full pipeline: %0d", input_stalls);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
